// ----- hdl/tmrp_pkg.sv -----
// Shared types and constants for the timed motion record/playback block.
package tmrp_pkg;

   localparam int STORE_DEPTH_DEF = 1024;
   localparam int VALUE_WIDTH_DEF = 16;

   localparam int TIME_WIDTH  = 32;
   localparam int DELTA_WIDTH = 20;
   localparam int CMD_WIDTH   = 3;

   localparam logic [DELTA_WIDTH-1:0] INTERVAL_RESET = 20'd50000;

   // command codes
   localparam logic [CMD_WIDTH-1:0] CMD_START_REC  = 3'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_STOP_REC   = 3'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_START_PLAY = 3'd2;
   localparam logic [CMD_WIDTH-1:0] CMD_STOP_PLAY  = 3'd3;
   localparam logic [CMD_WIDTH-1:0] CMD_TICK       = 3'd4;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic ready;
      logic accept;
      logic commit;
   } seq_ctl_type;

endpackage

// ----- hdl/tmrp_req_if.sv -----
// Input item channel: command, tick delta and the pose to record.
interface tmrp_req_if #(
   parameter int VALUE_WIDTH = tmrp_pkg::VALUE_WIDTH_DEF
);
   logic                                valid;
   logic                                ready;
   logic [tmrp_pkg::CMD_WIDTH-1:0]      command;
   logic [tmrp_pkg::DELTA_WIDTH-1:0]    delta_time_us;
   logic signed [VALUE_WIDTH-1:0]       joint0_in;
   logic signed [VALUE_WIDTH-1:0]       joint1_in;
   logic signed [VALUE_WIDTH-1:0]       joint2_in;
   logic signed [VALUE_WIDTH-1:0]       grip_in;
   logic                                grabbing_in;

   modport source (
      output valid, command, delta_time_us, joint0_in, joint1_in, joint2_in,
             grip_in, grabbing_in,
      input  ready
   );
   modport sink (
      input  valid, command, delta_time_us, joint0_in, joint1_in, joint2_in,
             grip_in, grabbing_in,
      output ready
   );
endinterface

// ----- hdl/tmrp_rsp_if.sv -----
// Result item channel: played back pose and status.
interface tmrp_rsp_if #(
   parameter int VALUE_WIDTH = tmrp_pkg::VALUE_WIDTH_DEF,
   parameter int COUNT_WIDTH = 11
);
   logic                          valid;
   logic                          ready;
   logic                          sample_valid;
   logic signed [VALUE_WIDTH-1:0] joint0_out;
   logic signed [VALUE_WIDTH-1:0] joint1_out;
   logic signed [VALUE_WIDTH-1:0] joint2_out;
   logic signed [VALUE_WIDTH-1:0] grip_out;
   logic                          grabbing_out;
   logic                          playing_status;
   logic                          recording_status;
   logic [COUNT_WIDTH-1:0]        stored_count;
   logic                          store_full;

   modport source (
      output valid, sample_valid, joint0_out, joint1_out, joint2_out, grip_out,
             grabbing_out, playing_status, recording_status, stored_count,
             store_full,
      input  ready
   );
   modport sink (
      input  valid, sample_valid, joint0_out, joint1_out, joint2_out, grip_out,
             grabbing_out, playing_status, recording_status, stored_count,
             store_full,
      output ready
   );
endinterface

// ----- hdl/tmrp_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
module tmrp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/tmrp_seq.sv -----
// Two-step sequencer: accept (issue store read), then execute and commit.
module tmrp_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  slot_free,
   output tmrp_pkg::seq_ctl_type ctl
);

   tmrp_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tmrp_pkg::ST_IDLE: begin
            if (req_valid) state_in = tmrp_pkg::ST_EXEC;
         end
         tmrp_pkg::ST_EXEC: begin
            if (slot_free) state_in = tmrp_pkg::ST_IDLE;
         end
         default: state_in = tmrp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctl = '0;
      unique case (state_ff)
         tmrp_pkg::ST_IDLE: begin
            ctl.ready  = 1'b1;
            ctl.accept = req_valid;
         end
         tmrp_pkg::ST_EXEC: begin
            ctl.commit = slot_free;
         end
         default: ctl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tmrp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hdl/timed_motion_record_playback.sv -----
// Timed motion record/playback: records timestamped poses, replays them on ticks.
// A result item is registered in the execute/commit step that follows the accept step,
// which issues the read of the pose store. No new item is taken until that step commits;
//   a stalled result holds the execute step.
// Reset (synchronous, active high): modes off, timer, counts and flags cleared,
//   interval back to 50000 us; store contents are left as they are (never read unwritten).
module timed_motion_record_playback #(
   parameter int STORE_DEPTH = tmrp_pkg::STORE_DEPTH_DEF,
   parameter int VALUE_WIDTH = tmrp_pkg::VALUE_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   tmrp_req_if.sink                          req_if,
   tmrp_rsp_if.source                        rsp_if,
   input  logic                              csr_we,
   input  logic [tmrp_pkg::DELTA_WIDTH-1:0]  csr_wdata
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int CW = $clog2(STORE_DEPTH + 1);
   localparam int TW = tmrp_pkg::TIME_WIDTH;
   localparam int DW = tmrp_pkg::DELTA_WIDTH;
   localparam int PW = 4 * VALUE_WIDTH + 1;   // packed pose: j0, j1, j2, grip, grab
   localparam int EW = TW + PW;               // store entry: time stamp over pose

   // ---------------------------------------------------------------------------
   // Architectural state
   // ---------------------------------------------------------------------------
   logic [DW-1:0] interval_ff;
   logic [TW-1:0] timer_ff, timer_in;
   logic [TW-1:0] last_ff, last_in;
   logic          rec_ff, rec_in;
   logic          play_ff, play_in;
   logic          ovf_ff, ovf_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] pos_ff, pos_in;

   // Item captured at accept, with the timer sums precomputed so the execute
   // cycle only compares.
   logic [tmrp_pkg::CMD_WIDTH-1:0] cmd_ff;
   logic [PW-1:0]                  pose_ff;
   logic [TW-1:0]                  t1_ff, t1_in;    // timer + delta, saturated
   logic [TW-1:0]                  t2_ff, t2_in;    // timer + 2*delta, saturated
   logic [TW:0]                    lim_ff, lim_in;  // last stored time + interval

   // Result register
   logic          rsp_valid_ff;
   logic          emit;
   logic [PW-1:0] entry_pose;

   tmrp_pkg::seq_ctl_type ctl;
   logic                  slot_free;

   logic [EW-1:0] rd_data;
   logic          wr_en;

   assign slot_free = !rsp_valid_ff || rsp_if.ready;

   tmrp_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .slot_free (slot_free),
      .ctl       (ctl)
   );

   assign req_if.ready = ctl.ready;

   // ---------------------------------------------------------------------------
   // Accept cycle: saturating timer sums and the sample deadline
   // ---------------------------------------------------------------------------
   logic [TW:0] sum1, sum2;

   always_comb begin
      sum1   = {1'b0, timer_ff} + (TW+1)'(req_if.delta_time_us);
      sum2   = {1'b0, timer_ff} + (TW+1)'({req_if.delta_time_us, 1'b0});
      t1_in  = sum1[TW] ? '1 : sum1[TW-1:0];
      t2_in  = sum2[TW] ? '1 : sum2[TW-1:0];
      lim_in = {1'b0, last_ff} + (TW+1)'(interval_ff);
   end

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         cmd_ff  <= req_if.command;
         pose_ff <= {req_if.joint0_in, req_if.joint1_in, req_if.joint2_in,
                     req_if.grip_in, req_if.grabbing_in};
         t1_ff   <= t1_in;
         t2_ff   <= t2_in;
         lim_ff  <= lim_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Pose store: read at the play position on accept, written on commit
   // ---------------------------------------------------------------------------
   logic do_store;

   assign wr_en = ctl.commit && do_store;

   tmrp_ram #(
      .WIDTH (EW),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data ({t1_ff, pose_ff}),
      .rd_en   (ctl.accept),
      .rd_addr (pos_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // ---------------------------------------------------------------------------
   // Execute cycle: record step, then playback step
   // ---------------------------------------------------------------------------
   logic          is_tick, due, has_room, do_ovf, play_run, fwd, play_end;
   logic [CW-1:0] count_rec, pos_play;
   logic [TW-1:0] timer_rec, play_time, entry_time;

   always_comb begin
      is_tick   = (cmd_ff == tmrp_pkg::CMD_TICK);
      due       = (count_ff == '0) || ({1'b0, t1_ff} > lim_ff);
      has_room  = (count_ff < CW'(STORE_DEPTH));
      do_store  = is_tick && rec_ff && due && has_room;
      do_ovf    = is_tick && rec_ff && due && !has_room;
      count_rec = do_store ? count_ff + 1'b1 : count_ff;
      timer_rec = (is_tick && rec_ff) ? t1_ff : timer_ff;

      // both modes advance the shared timer by delta on the same tick
      play_run  = is_tick && play_ff && (pos_ff < count_rec);
      play_time = rec_ff ? t2_ff : t1_ff;

      // entry being written this tick is the one to be played: bypass the store
      fwd        = do_store && (pos_ff == count_ff);
      entry_time = fwd ? t1_ff   : rd_data[EW-1:PW];
      entry_pose = fwd ? pose_ff : rd_data[PW-1:0];

      emit     = play_run && (play_time >= entry_time);
      pos_play = emit ? pos_ff + 1'b1 : pos_ff;
      play_end = (pos_play >= count_rec);
   end

   always_comb begin
      timer_in = timer_ff;
      last_in  = last_ff;
      rec_in   = rec_ff;
      play_in  = play_ff;
      ovf_in   = ovf_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      unique case (cmd_ff)
         tmrp_pkg::CMD_START_REC: begin
            count_in = '0;
            ovf_in   = 1'b0;
            last_in  = '0;
            rec_in   = 1'b1;
            timer_in = '0;
         end
         tmrp_pkg::CMD_STOP_REC: begin
            rec_in = 1'b0;
         end
         tmrp_pkg::CMD_START_PLAY: begin
            // ignored on an empty store
            if (count_ff != '0) begin
               play_in  = 1'b1;
               timer_in = '0;
               pos_in   = '0;
            end
         end
         tmrp_pkg::CMD_STOP_PLAY: begin
            play_in = 1'b0;
         end
         tmrp_pkg::CMD_TICK: begin
            count_in = count_rec;
            ovf_in   = ovf_ff || do_ovf;
            last_in  = do_store ? t1_ff : last_ff;
            timer_in = play_run ? play_time : timer_rec;
            pos_in   = pos_play;
            play_in  = play_ff && !play_end;
         end
         default: begin
            // unknown code: status only
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= tmrp_pkg::INTERVAL_RESET;
         timer_ff    <= '0;
         last_ff     <= '0;
         rec_ff      <= 1'b0;
         play_ff     <= 1'b0;
         ovf_ff      <= 1'b0;
         count_ff    <= '0;
         pos_ff      <= '0;
      end else begin
         if (csr_we) begin
            interval_ff <= csr_wdata;
         end
         if (ctl.commit) begin
            timer_ff <= timer_in;
            last_ff  <= last_in;
            rec_ff   <= rec_in;
            play_ff  <= play_in;
            ovf_ff   <= ovf_in;
            count_ff <= count_in;
            pos_ff   <= pos_in;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------------------
   logic [PW-1:0] out_pose;

   assign out_pose = emit ? entry_pose : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         rsp_if.sample_valid     <= emit;
         rsp_if.joint0_out       <= out_pose[PW-1 -: VALUE_WIDTH];
         rsp_if.joint1_out       <= out_pose[PW-1-VALUE_WIDTH -: VALUE_WIDTH];
         rsp_if.joint2_out       <= out_pose[PW-1-2*VALUE_WIDTH -: VALUE_WIDTH];
         rsp_if.grip_out         <= out_pose[VALUE_WIDTH:1];
         rsp_if.grabbing_out     <= out_pose[0];
         rsp_if.playing_status   <= play_in;
         rsp_if.recording_status <= rec_in;
         rsp_if.stored_count     <= count_in;
         rsp_if.store_full       <= ovf_in;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking bench for the timed motion record/playback block.
module tb;
   import tmrp_pkg::*;

   // stored_count on the result channel is 11 bits wide
   localparam int COUNT_W     = 11;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 8;
   localparam logic [DELTA_WIDTH-1:0] DELTA_MAX = 20'd1000000;

   typedef struct packed {
      logic signed [VALUE_WIDTH_DEF-1:0] j0;
      logic signed [VALUE_WIDTH_DEF-1:0] j1;
      logic signed [VALUE_WIDTH_DEF-1:0] j2;
      logic signed [VALUE_WIDTH_DEF-1:0] grip;
      logic                              grab;
   } arm_pose_type;

   typedef struct packed {
      logic [CMD_WIDTH-1:0]   command;
      logic [DELTA_WIDTH-1:0] delta_us;
      arm_pose_type           pose;
   } arm_cmd_type;

   typedef struct packed {
      logic               sample_valid;
      arm_pose_type       pose;
      logic               playing;
      logic               recording;
      logic [COUNT_W-1:0] stored;
      logic               full;
   } arm_rsp_type;

   localparam arm_pose_type POSE_LOW  = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 1'b1};
   localparam arm_pose_type POSE_HIGH = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 1'b0};

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [DELTA_WIDTH-1:0] csr_wdata;

   tmrp_req_if req_bus ();
   tmrp_rsp_if rsp_bus ();

   timed_motion_record_playback uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Shadow of the block state, advanced once per accepted item
   // ---------------------------------------------------------------------
   logic [TIME_WIDTH-1:0]  tmr_us;
   logic                   rec_on;
   logic                   play_on;
   logic [COUNT_W-1:0]     play_idx;
   logic [COUNT_W-1:0]     n_stored;
   logic                   drop_seen;
   logic [TIME_WIDTH-1:0]  last_keep_us;
   logic [DELTA_WIDTH-1:0] interval_us;
   logic [TIME_WIDTH-1:0]  keep_time [STORE_DEPTH_DEF];
   arm_pose_type           keep_pose [STORE_DEPTH_DEF];

   // bench bookkeeping
   arm_cmd_type cmd_backlog  [$];   // items waiting for the driver
   arm_rsp_type expected_rsp [$];   // predicted results, oldest first
   int       items_queued  = 0;
   int       items_checked = 0;
   int       cycle_count;
   bit       mismatch_seen = 1'b0;
   bit       req_fire      = 1'b0;
   int       send_idle_pct;
   int       recv_stall_pct;
   int       gen_interval  = 50000;   // interval as the generator sees it

   // timer never wraps: it sticks at all ones
   function automatic logic [TIME_WIDTH-1:0] sat_add(logic [TIME_WIDTH-1:0] t,
                                                     logic [DELTA_WIDTH-1:0] d);
      logic [TIME_WIDTH:0] s;
      s = {1'b0, t} + d;
      return s[TIME_WIDTH] ? '1 : s[TIME_WIDTH-1:0];
   endfunction

   // One command against the shadow state; returns the result it causes.
   function automatic arm_rsp_type predict_playback(arm_cmd_type c);
      arm_rsp_type r;
      r = '0;
      case (c.command)
         CMD_START_REC: begin
            // empties the store; a running playback keeps its flag
            n_stored     = '0;
            drop_seen    = 1'b0;
            last_keep_us = '0;
            rec_on       = 1'b1;
            tmr_us       = '0;
         end
         CMD_STOP_REC:  rec_on = 1'b0;
         CMD_START_PLAY: begin
            if (n_stored != 0) begin
               play_on  = 1'b1;
               tmr_us   = '0;
               play_idx = '0;
            end
         end
         CMD_STOP_PLAY: play_on = 1'b0;
         CMD_TICK: begin
            // record step first, then playback; each adds the delta
            if (rec_on) begin
               tmr_us = sat_add(tmr_us, c.delta_us);
               if (n_stored == 0 || {1'b0, tmr_us} > {1'b0, last_keep_us} + interval_us) begin
                  if (n_stored >= STORE_DEPTH_DEF) begin
                     drop_seen = 1'b1;
                  end else begin
                     keep_time[n_stored] = tmr_us;
                     keep_pose[n_stored] = c.pose;
                     last_keep_us        = tmr_us;
                     n_stored++;
                  end
               end
            end
            if (play_on) begin
               if (play_idx < n_stored) begin
                  tmr_us = sat_add(tmr_us, c.delta_us);
                  if (tmr_us >= keep_time[play_idx]) begin
                     r.sample_valid = 1'b1;
                     r.pose         = keep_pose[play_idx];
                     play_idx++;
                  end
               end
               // past the last entry (or store emptied): playback ends now
               if (play_idx >= n_stored) play_on = 1'b0;
            end
         end
         default: ;   // unused codes only report status
      endcase
      r.playing   = play_on;
      r.recording = rec_on;
      r.stored    = n_stored;
      r.full      = drop_seen;
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         mismatch_seen = 1'b1;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Driver: items leave the backlog at falling edges, held until taken
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      arm_cmd_type nxt;
      logic        send;
      send = 1'b0;
      nxt  = '0;
      if (!reset && (!req_bus.valid || req_fire)) begin
         if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt  = cmd_backlog.pop_front();
            send = 1'b1;
         end
         req_bus.valid <= send;
         if (send) begin
            req_bus.command       <= nxt.command;
            req_bus.delta_time_us <= nxt.delta_us;
            req_bus.joint0_in     <= nxt.pose.j0;
            req_bus.joint1_in     <= nxt.pose.j1;
            req_bus.joint2_in     <= nxt.pose.j2;
            req_bus.grip_in       <= nxt.pose.grip;
            req_bus.grabbing_in   <= nxt.pose.grab;
         end
      end
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // ---------------------------------------------------------------------
   // Monitor: predict on input handshakes, compare on result handshakes
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      arm_cmd_type took;
      arm_rsp_type want;
      if (reset) begin
         tmr_us       = '0;
         rec_on       = 1'b0;
         play_on      = 1'b0;
         play_idx     = '0;
         n_stored     = '0;
         drop_seen    = 1'b0;
         last_keep_us = '0;
         interval_us  = INTERVAL_RESET;
      end else begin
         if (csr_we) interval_us = csr_wdata;
         if (req_bus.valid && req_bus.ready) begin
            took.command   = req_bus.command;
            took.delta_us  = req_bus.delta_time_us;
            took.pose.j0   = req_bus.joint0_in;
            took.pose.j1   = req_bus.joint1_in;
            took.pose.j2   = req_bus.joint2_in;
            took.pose.grip = req_bus.grip_in;
            took.pose.grab = req_bus.grabbing_in;
            want = predict_playback(took);
            expected_rsp.insert(expected_rsp.size(), want);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_rsp.size() == 0) begin
               $error("result item with no expectation waiting");
               mismatch_seen = 1'b1;
            end else begin
               want = expected_rsp.pop_front();
               check_field("sample_valid", want.sample_valid, rsp_bus.sample_valid);
               check_field("joint0_out", want.pose.j0, rsp_bus.joint0_out);
               check_field("joint1_out", want.pose.j1, rsp_bus.joint1_out);
               check_field("joint2_out", want.pose.j2, rsp_bus.joint2_out);
               check_field("grip_out", want.pose.grip, rsp_bus.grip_out);
               check_field("grabbing_out", want.pose.grab, rsp_bus.grabbing_out);
               check_field("playing_status", want.playing, rsp_bus.playing_status);
               check_field("recording_status", want.recording, rsp_bus.recording_status);
               check_field("stored_count", want.stored, rsp_bus.stored_count);
               check_field("store_full", want.full, rsp_bus.store_full);
               items_checked++;
            end
         end
      end
      req_fire = !reset && req_bus.valid && req_bus.ready;
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic logic [VALUE_WIDTH_DEF-1:0] rand_word();
      case ($urandom_range(7))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2:       return 16'h0000;
         3:       return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic arm_pose_type rand_pose();
      arm_pose_type p;
      p.j0   = rand_word();
      p.j1   = rand_word();
      p.j2   = rand_word();
      p.grip = rand_word();
      p.grab = 1'($urandom);
      return p;
   endfunction

   // deltas mostly scaled to the interval so samples get stored and skipped
   function automatic logic [DELTA_WIDTH-1:0] rand_delta();
      int hi;
      hi = (gen_interval > 499999) ? int'(DELTA_MAX) : 2 * gen_interval + 2;
      case ($urandom_range(9))
         0:       return '0;
         1:       return DELTA_MAX;
         2, 3:    return DELTA_WIDTH'($urandom_range(0, int'(DELTA_MAX)));
         default: return DELTA_WIDTH'($urandom_range(0, hi));
      endcase
   endfunction

   task automatic queue_item(logic [CMD_WIDTH-1:0] cmd, logic [DELTA_WIDTH-1:0] delta,
                             arm_pose_type pose);
      arm_cmd_type c;
      c = '{cmd, delta, pose};
      cmd_backlog.insert(cmd_backlog.size(), c);
      items_queued++;
   endtask

   task automatic queue_tick();
      queue_item(CMD_TICK, rand_delta(), rand_pose());
   endtask

   // record a take, replay it, sometimes break it off
   task automatic queue_session(int max_ticks);
      int n;
      if ($urandom_range(7) == 0) begin
         // noise: any code, including the unused ones
         repeat ($urandom_range(1, 3))
            queue_item(CMD_WIDTH'($urandom_range(0, (1 << CMD_WIDTH) - 1)),
                       rand_delta(), rand_pose());
      end
      queue_item(CMD_START_REC, rand_delta(), rand_pose());
      repeat ($urandom_range(1, max_ticks)) queue_tick();
      // keep recording during playback now and then
      if ($urandom_range(3) != 0) queue_item(CMD_STOP_REC, rand_delta(), rand_pose());
      queue_item(CMD_START_PLAY, rand_delta(), rand_pose());
      n = $urandom_range(1, max_ticks);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(19) == 0) queue_item(CMD_START_PLAY, rand_delta(), rand_pose());
         queue_tick();
      end
      case ($urandom_range(3))
         0: queue_item(CMD_STOP_PLAY, rand_delta(), rand_pose());
         1: begin
            // store emptied under a running playback
            queue_item(CMD_START_REC, rand_delta(), rand_pose());
            queue_item(CMD_STOP_REC, rand_delta(), rand_pose());
            queue_tick();
         end
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (items_checked != items_queued) @(posedge clock);
      @(negedge clock);
   endtask

   // interval changes only with nothing in flight
   task automatic write_interval(logic [DELTA_WIDTH-1:0] v);
      wait_drained();
      csr_wdata <= v;
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we    <= 1'b0;
      gen_interval = int'(v);
   endtask

   task automatic fill_phase(int n_items, int max_ticks);
      int base;
      base = items_queued;
      while (items_queued - base < n_items) queue_session(max_ticks);
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_wdata             = '0;
      req_bus.valid         = 1'b0;
      req_bus.command       = CMD_STOP_REC;
      req_bus.delta_time_us = '0;
      req_bus.joint0_in     = '0;
      req_bus.joint1_in     = '0;
      req_bus.joint2_in     = '0;
      req_bus.grip_in       = '0;
      req_bus.grabbing_in   = 1'b0;
      rsp_bus.ready         = 1'b0;
      send_idle_pct         = 14;
      recv_stall_pct        = 51;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, interval at its reset value
      queue_item(CMD_STOP_REC, '0, rand_pose());          // nothing running
      queue_item(CMD_START_PLAY, DELTA_MAX, rand_pose()); // empty store: ignored
      queue_item(CMD_STOP_PLAY, '0, rand_pose());
      queue_item(CMD_TICK, DELTA_MAX, rand_pose());       // idle tick: status only
      queue_item(CMD_WIDTH'(CMD_TICK + 1), DELTA_MAX, rand_pose());  // unused codes
      queue_item('1, '0, rand_pose());
      queue_item(CMD_START_REC, '0, rand_pose());
      queue_item(CMD_TICK, '0, POSE_LOW);                 // empty store: kept at time 0
      queue_item(CMD_TICK, INTERVAL_RESET, rand_pose());  // exactly the interval: skipped
      queue_item(CMD_TICK, 20'd1, POSE_HIGH);             // one past: kept
      queue_item(CMD_TICK, DELTA_MAX, rand_pose());
      queue_item(CMD_START_PLAY, '0, rand_pose());        // both modes on
      queue_item(CMD_TICK, '0, rand_pose());              // timer behind last stored time
      queue_item(CMD_TICK, '0, rand_pose());              // next entry not due
      queue_item(CMD_STOP_REC, '0, rand_pose());
      queue_item(CMD_TICK, DELTA_MAX, rand_pose());
      queue_item(CMD_TICK, '0, rand_pose());
      queue_item(CMD_TICK, DELTA_MAX, rand_pose());       // last entry: playback ends
      queue_item(CMD_START_PLAY, '0, rand_pose());
      queue_item(CMD_TICK, DELTA_MAX, rand_pose());
      queue_item(CMD_START_REC, '0, rand_pose());         // empties store mid playback
      queue_item(CMD_STOP_REC, '0, rand_pose());
      queue_item(CMD_TICK, rand_delta(), rand_pose());

      // phase 1: no interval at all, receiver stalls a lot
      write_interval('0);
      // long take: every tick with a nonzero delta is kept, so the store
      // fills and the last few samples are dropped
      queue_item(CMD_START_REC, '0, rand_pose());
      repeat (STORE_DEPTH_DEF + 6)
         queue_item(CMD_TICK, DELTA_WIDTH'($urandom_range(1, int'(DELTA_MAX))),
                    rand_pose());
      queue_item(CMD_START_PLAY, '0, rand_pose());
      repeat (8) queue_tick();
      queue_item(CMD_STOP_PLAY, '0, rand_pose());
      queue_item(CMD_STOP_REC, '0, rand_pose());
      fill_phase(25, 10);

      // phase 2: interval at DELTA_MAX, sender idles a lot
      write_interval(DELTA_MAX);
      send_idle_pct  = 51;
      recv_stall_pct = 14;
      fill_phase(25, 10);

      // phase 3: mid interval, both sides at full rate
      write_interval(DELTA_WIDTH'($urandom_range(1, 200000)));
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      fill_phase(25, 10);

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (!mismatch_seen && expected_rsp.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
